// File: rtl/mi4_pkg.sv
// shared constants, types and index helpers for the 4x4 matrix inverter
`default_nettype none
package mi4_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int ELEM_W        = 16;
  localparam int IDX_W         = 4;
  localparam int PAIR_W        = 2 * VALUE_WIDTH;
  localparam int PROD_W        = 3 * VALUE_WIDTH;
  localparam int COF_W         = 3 * VALUE_WIDTH + 1;
  localparam int DET_W         = 4 * VALUE_WIDTH + 2;
  localparam int REM_W         = DET_W + 1;
  localparam int NUM_W         = PROD_W + 2 * FRACTION_BITS;
  localparam int DIV_CNT_W     = $clog2(NUM_W);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(15);
  localparam logic [2:0]       LAST_TERM = 3'd5;
  localparam logic [2:0]       LAST_PHASE = 3'd4;
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(3);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_TERM_A,
    DP_TERM_B,
    DP_TERM_C,
    DP_TERM_ACC,
    DP_COF_WR,
    DP_DET_MUL,
    DP_DET_ACC,
    DP_SETUP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_FIN,
    DP_SING
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TERM,
    ST_COF_WR,
    ST_DET,
    ST_CHECK,
    ST_DIV_RD,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_SING
  } ctl_state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] mat_addr;
    logic [IDX_W-1:0] cof_addr;
    logic             neg;
    logic             first;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic det_zero;
  } dp_stat_t;

  // minor column for term t, minor row j (six permutations, odd ones last)
  function automatic logic [1:0] perm_col(logic [2:0] t, logic [1:0] j);
    logic [5:0] p;
    case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      default: p = {2'd2, 2'd0, 2'd1};
    endcase
    return p[{j, 1'b0} +: 2];
  endfunction

  // row-major address of factor j of term t of the cofactor at row n[1:0], col n[3:2]
  function automatic logic [IDX_W-1:0] minor_addr(logic [IDX_W-1:0] n, logic [2:0] t,
                                                  logic [1:0] j);
    logic [1:0] pc;
    logic [1:0] mr;
    logic [1:0] ac;
    pc = perm_col(t, j);
    mr = (j >= n[1:0]) ? j + 2'd1 : j;
    ac = (pc >= n[3:2]) ? pc + 2'd1 : pc;
    return {mr, ac};
  endfunction

  function automatic logic term_neg(logic [IDX_W-1:0] n, logic [2:0] t);
    return (t >= 3'd3) ^ n[0] ^ n[2];
  endfunction

endpackage
`default_nettype wire

// File: rtl/matrix_inverse_4x4.sv
// top level of the 4x4 fixed-point matrix inverter
// Takes 16 signed Q8.8 elements in row-major order, one beat per cycle while
// in_ready_o is high, then forms the cofactors and the determinant exactly and
// returns 16 quotients (or one singular result). The 16 cofactors go through one
// shared multiplier chain as six triple products each; the determinant follows.
// Each quotient comes from a one-bit-per-cycle divider over 64 steps. Input is not
// taken again until the last quotient, or the singular result, has been handed to
// the output register.
`default_nettype none
module matrix_inverse_4x4
  import mi4_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [ELEM_W-1:0] element_value_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic [ELEM_W-1:0] inverse_value_o,
  output logic  [IDX_W-1:0] element_index_o,
  output logic              singular_o,
  output logic              saturated_o,
  output logic              run_last_o,
  output logic              out_valid_o,
  input  wire               out_ready_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mi4_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mi4_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .element_value_i(element_value_i),
    .stat_o         (stat),
    .inverse_value_o(inverse_value_o),
    .element_index_o(element_index_o),
    .singular_o     (singular_o),
    .saturated_o    (saturated_o),
    .run_last_o     (run_last_o)
  );

  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> run_last_o && !saturated_o)
    else $error("singular beat not marked last");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inverse_value_o == '0 && element_index_o == '0)
    else $error("singular beat carries data");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o && !singular_o |-> element_index_o == LAST_IDX)
    else $error("last beat at wrong index");

endmodule
`default_nettype wire

// File: rtl/mi4_datapath.sv
// datapath: element and cofactor memories, shared multiplier chain, serial divider
`default_nettype none
module mi4_datapath
  import mi4_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  wire        [ELEM_W-1:0] element_value_i,
  output dp_stat_t                stat_o,
  output logic       [ELEM_W-1:0] inverse_value_o,
  output logic        [IDX_W-1:0] element_index_o,
  output logic                    singular_o,
  output logic                    saturated_o,
  output logic                    run_last_o
);

  localparam logic [NUM_W-1:0] PosMax = NUM_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic [NUM_W-1:0] NegMag = NUM_W'(64'd1 << (VALUE_WIDTH - 1));

  logic signed [VALUE_WIDTH-1:0] mat_mem [16];
  logic signed [COF_W-1:0]       cof_mem [16];
  logic signed [VALUE_WIDTH-1:0] mat_rd_q;
  logic signed [COF_W-1:0]       cof_rd_q;

  logic signed [VALUE_WIDTH-1:0] a_q;
  logic signed [PAIR_W-1:0]      ab_q;
  logic signed [PROD_W-1:0]      abc_q;
  logic signed [COF_W-1:0]       acc_q, acc_d, prod_ext;
  logic signed [DET_W-1:0]       dprod_q, det_q, det_d;
  logic        [DET_W-1:0]       dmag_q;
  logic                          dneg_q;
  logic        [NUM_W-1:0]       num_q, q_q;
  logic        [REM_W-1:0]       rem_q, rem_sh;
  logic                          rem_ge;
  logic                          div_neg_q;
  logic        [COF_W-1:0]       cmag;
  logic signed [VALUE_WIDTH-1:0] res;
  logic                          sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      mat_mem[cmd_i.mat_addr] <= element_value_i[VALUE_WIDTH-1:0];
    end
    mat_rd_q <= mat_mem[cmd_i.mat_addr];
    if (cmd_i.op == DP_COF_WR) begin
      cof_mem[cmd_i.cof_addr] <= acc_q;
    end
    cof_rd_q <= cof_mem[cmd_i.cof_addr];
  end

  assign prod_ext = COF_W'(abc_q);
  assign acc_d = cmd_i.neg ? ((cmd_i.first ? '0 : acc_q) - prod_ext)
                           : ((cmd_i.first ? '0 : acc_q) + prod_ext);
  assign det_d = (cmd_i.first ? '0 : det_q) + dprod_q;
  assign cmag  = cof_rd_q[COF_W-1] ? COF_W'(-cof_rd_q) : COF_W'(cof_rd_q);

  assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dmag_q};

  always_comb begin
    if (div_neg_q) begin
      sat = q_q > NegMag;
      res = sat ? VALUE_WIDTH'(-NegMag) : VALUE_WIDTH'(-q_q[VALUE_WIDTH-1:0]);
    end else begin
      sat = q_q > PosMax;
      res = sat ? PosMax[VALUE_WIDTH-1:0] : q_q[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_TERM_A:   a_q     <= mat_rd_q;
      DP_TERM_B:   ab_q    <= a_q * mat_rd_q;
      DP_TERM_C:   abc_q   <= ab_q * mat_rd_q;
      DP_TERM_ACC: acc_q   <= acc_d;
      DP_DET_MUL:  dprod_q <= mat_rd_q * cof_rd_q;
      DP_SETUP: begin
        dneg_q <= det_q[DET_W-1];
        dmag_q <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      end
      DP_DIV_INIT: begin
        div_neg_q <= cof_rd_q[COF_W-1] ^ dneg_q;
        num_q     <= {cmag[PROD_W-1:0], {(2 * FRACTION_BITS){1'b0}}};
        rem_q     <= '0;
        q_q       <= '0;
      end
      DP_DIV_STEP: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= rem_ge ? rem_sh - {1'b0, dmag_q} : rem_sh;
        q_q   <= {q_q[NUM_W-2:0], rem_ge};
      end
      DP_DIV_FIN: begin
        inverse_value_o <= ELEM_W'(res);
        element_index_o <= cmd_i.cof_addr;
        singular_o      <= 1'b0;
        saturated_o     <= sat;
        run_last_o      <= cmd_i.last;
      end
      DP_SING: begin
        inverse_value_o <= '0;
        element_index_o <= '0;
        singular_o      <= 1'b1;
        saturated_o     <= 1'b0;
        run_last_o      <= 1'b1;
      end
      default: ;
    endcase
  end

  // determinant register is the only state with a defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q <= '0;
    end else if (cmd_i.op == DP_DET_ACC) begin
      det_q <= det_d;
    end
  end

  assign stat_o.det_zero = (det_q == '0);

endmodule
`default_nettype wire

// File: rtl/mi4_controller.sv
// controller: load counting, cofactor/determinant sequencing, divider and output control
`default_nettype none
module mi4_controller
  import mi4_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctl_state_e           state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [2:0]           t_q, t_d;
  logic [2:0]           ph_q, ph_d;
  logic [DIV_CNT_W-1:0] dc_q, dc_d;
  logic                 ov_q, ov_d;
  logic                 out_free;

  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      t_q     <= '0;
      ph_q    <= '0;
      dc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      t_q     <= t_d;
      ph_q    <= ph_d;
      dc_q    <= dc_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    t_d            = t_q;
    ph_d           = ph_q;
    dc_d           = dc_q;
    ov_d           = ov_q && !out_ready_i;
    cmd_o.op       = DP_NOP;
    cmd_o.mat_addr = cnt_q;
    cmd_o.cof_addr = cnt_q;
    cmd_o.neg      = term_neg(cnt_q, t_q);
    cmd_o.first    = 1'b0;
    cmd_o.last     = (cnt_q == LAST_IDX);
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          cnt_d    = cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_d = ST_TERM;
            t_d     = '0;
            ph_d    = '0;
          end
        end
      end
      ST_TERM: begin
        // read issued one phase ahead of its use
        cmd_o.mat_addr = minor_addr(cnt_q, t_q, ph_q[1:0]);
        cmd_o.first    = (t_q == 3'd0);
        case (ph_q)
          3'd1:    cmd_o.op = DP_TERM_A;
          3'd2:    cmd_o.op = DP_TERM_B;
          3'd3:    cmd_o.op = DP_TERM_C;
          3'd4:    cmd_o.op = DP_TERM_ACC;
          default: cmd_o.op = DP_NOP;
        endcase
        if (ph_q == LAST_PHASE) begin
          ph_d = '0;
          if (t_q == LAST_TERM) begin
            state_d = ST_COF_WR;
          end else begin
            t_d = t_q + 3'd1;
          end
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      ST_COF_WR: begin
        cmd_o.op = DP_COF_WR;
        t_d      = '0;
        ph_d     = '0;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DET;
        end else begin
          state_d = ST_TERM;
        end
      end
      ST_DET: begin
        cmd_o.cof_addr = {cnt_q[1:0], 2'b00};
        cmd_o.first    = (cnt_q == '0);
        case (ph_q)
          3'd1:    cmd_o.op = DP_DET_MUL;
          3'd2:    cmd_o.op = DP_DET_ACC;
          default: cmd_o.op = DP_NOP;
        endcase
        if (ph_q == 3'd2) begin
          ph_d = '0;
          if (cnt_q == LAST_ROW) begin
            state_d = ST_CHECK;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      ST_CHECK: begin
        cmd_o.op = DP_SETUP;
        state_d  = stat_i.det_zero ? ST_SING : ST_DIV_RD;
      end
      ST_DIV_RD: begin
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = DP_DIV_INIT;
        dc_d     = DIV_CNT_W'(NUM_W - 1);
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = DP_DIV_STEP;
        dc_d     = dc_q - 1'b1;
        if (dc_q == '0) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        if (out_free) begin
          cmd_o.op = DP_DIV_FIN;
          ov_d     = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          state_d  = (cnt_q == LAST_IDX) ? ST_LOAD : ST_DIV_RD;
        end
      end
      ST_SING: begin
        if (out_free) begin
          cmd_o.op = DP_SING;
          ov_d     = 1'b1;
          cnt_d    = '0;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire
